@@ rtl/mlas_pkg.sv @@
// shared types, register map and constants of the motion light alarm sequencer
package mlas_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int LIGHT_WIDTH_DEF  = 24;

    localparam int LIGHT_THR_W  = 24;
    localparam int GYRO_THR_W   = 16;
    localparam int MOTION_THR_W = 15;
    localparam int MOTION_SQ_W  = 2 * MOTION_THR_W;
    localparam int TICK_W       = 8;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // register indexes, byte address is 4 * index
    localparam logic [2:0] REG_LIGHT_THR  = 3'd0;
    localparam logic [2:0] REG_GYRO_THR   = 3'd1;
    localparam logic [2:0] REG_MOTION_THR = 3'd2;
    localparam logic [2:0] REG_BUZZ_TICKS = 3'd3;
    localparam logic [2:0] REG_WAIT_TICKS = 3'd4;

    localparam logic [LIGHT_THR_W-1:0]  LIGHT_THR_RST  = 24'd30000;
    localparam logic [GYRO_THR_W-1:0]   GYRO_THR_RST   = 16'd15000;
    localparam logic [MOTION_THR_W-1:0] MOTION_THR_RST = 15'd15000;
    localparam logic [MOTION_SQ_W-1:0]  MOTION_SQ_RST  = 30'd225000000;
    localparam logic [TICK_W-1:0]       BUZZ_TICKS_RST = 8'd8;
    localparam logic [TICK_W-1:0]       WAIT_TICKS_RST = 8'd16;
    localparam logic [TICK_W-1:0]       TICK_MAX       = 8'd255;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_INTERIM = 2'd1;
    localparam logic [1:0] PH_BUZZ    = 2'd2;
    localparam logic [1:0] PH_WAIT    = 2'd3;

    typedef struct packed {
        logic [LIGHT_THR_W-1:0] light_thr;
        logic [GYRO_THR_W-1:0]  gyro_thr;
        logic [MOTION_SQ_W-1:0] motion_sq;
        logic [TICK_W-1:0]      buzz_ticks;
        logic [TICK_W-1:0]      wait_ticks;
    } cfg_t;

    // events of one tick handed from detection to the phase machine
    typedef struct packed {
        logic valid;
        logic live;
        logic gyro_motion;
        logic light_jump;
    } det_flags_t;

endpackage

@@ rtl/mlas_if.sv @@
// valid/ready channel interfaces for sample and result transactions
interface mlas_sample_if #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int LIGHT_WIDTH  = 24
);
    logic                           valid;
    logic                           ready;
    logic [LIGHT_WIDTH-1:0]         light_level;
    logic                           light_valid;
    logic signed [SAMPLE_WIDTH-1:0] gyro_x;
    logic signed [SAMPLE_WIDTH-1:0] gyro_y;
    logic signed [SAMPLE_WIDTH-1:0] gyro_z;
    logic signed [SAMPLE_WIDTH-1:0] accel_x;
    logic signed [SAMPLE_WIDTH-1:0] accel_y;
    logic signed [SAMPLE_WIDTH-1:0] accel_z;

    modport source (
        output valid, light_level, light_valid, gyro_x, gyro_y, gyro_z,
               accel_x, accel_y, accel_z,
        input  ready
    );
    modport sink (
        input  valid, light_level, light_valid, gyro_x, gyro_y, gyro_z,
               accel_x, accel_y, accel_z,
        output ready
    );
endinterface

interface mlas_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] alarm_mode;
    logic       buzzer_on;
    logic       motion_seen;
    logic       light_jump_seen;

    modport source (
        output valid, alarm_mode, buzzer_on, motion_seen, light_jump_seen,
        input  ready
    );
    modport sink (
        input  valid, alarm_mode, buzzer_on, motion_seen, light_jump_seen,
        output ready
    );
endinterface

@@ rtl/mlas_cfg.sv @@
// apb register file holding thresholds and phase tick counts
module mlas_cfg
    import mlas_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [LIGHT_THR_W-1:0]  light_thr_reg;
    logic [GYRO_THR_W-1:0]   gyro_thr_reg;
    logic [MOTION_THR_W-1:0] motion_thr_reg;
    logic [MOTION_SQ_W-1:0]  motion_sq_reg;
    logic [TICK_W-1:0]       buzz_ticks_reg;
    logic [TICK_W-1:0]       wait_ticks_reg;
    logic [2:0]              reg_idx;
    logic                    wr_en;
    logic [MOTION_THR_W-1:0] wr_motion;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[4:2];
    assign wr_en     = psel && penable && pwrite;
    assign wr_motion = pwdata[MOTION_THR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_thr_reg  <= LIGHT_THR_RST;
            gyro_thr_reg   <= GYRO_THR_RST;
            motion_thr_reg <= MOTION_THR_RST;
            motion_sq_reg  <= MOTION_SQ_RST;
            buzz_ticks_reg <= BUZZ_TICKS_RST;
            wait_ticks_reg <= WAIT_TICKS_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_LIGHT_THR:  light_thr_reg <= pwdata[LIGHT_THR_W-1:0];
                REG_GYRO_THR:   gyro_thr_reg  <= pwdata[GYRO_THR_W-1:0];
                REG_MOTION_THR:
                begin
                    motion_thr_reg <= wr_motion;
                    // squared once here so the per-tick compare needs no multiplier
                    motion_sq_reg  <= MOTION_SQ_W'(wr_motion) * MOTION_SQ_W'(wr_motion);
                end
                REG_BUZZ_TICKS: buzz_ticks_reg <= pwdata[TICK_W-1:0];
                REG_WAIT_TICKS: wait_ticks_reg <= pwdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_LIGHT_THR:  prdata = APB_DATA_W'(light_thr_reg);
            REG_GYRO_THR:   prdata = APB_DATA_W'(gyro_thr_reg);
            REG_MOTION_THR: prdata = APB_DATA_W'(motion_thr_reg);
            REG_BUZZ_TICKS: prdata = APB_DATA_W'(buzz_ticks_reg);
            REG_WAIT_TICKS: prdata = APB_DATA_W'(wait_ticks_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.light_thr  = light_thr_reg;
    assign cfg.gyro_thr   = gyro_thr_reg;
    assign cfg.motion_sq  = motion_sq_reg;
    assign cfg.buzz_ticks = buzz_ticks_reg;
    assign cfg.wait_ticks = wait_ticks_reg;

endmodule

@@ rtl/mlas_detect.sv @@
// input register, previous-reading store, gyro and light change detection, accel squares
module mlas_detect
    import mlas_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int LIGHT_WIDTH  = LIGHT_WIDTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  cfg_t                       cfg,
    mlas_sample_if.sink                sample,
    output det_flags_t                 flags,
    output logic [2*SAMPLE_WIDTH-1:0]  accel_sq [3]
);

    localparam int SW  = SAMPLE_WIDTH;
    localparam int LW  = LIGHT_WIDTH;
    localparam int GW  = (SW + 1 > GYRO_THR_W) ? SW + 1 : GYRO_THR_W;
    localparam int LCW = (LW > LIGHT_THR_W) ? LW : LIGHT_THR_W;

    logic                 s1_valid_reg;
    logic [LW-1:0]        light_reg;
    logic                 light_ok_reg;
    logic signed [SW-1:0] gyro_reg [3];
    logic signed [SW-1:0] accel_reg [3];

    logic                 primed_reg;
    logic [LW-1:0]        last_light_reg;
    logic signed [SW-1:0] last_gyro_reg [3];

    det_flags_t           flags_reg;
    logic [2*SW-1:0]      sq_reg [3];

    logic [LW-1:0]        light_eff;
    logic [LW-1:0]        light_diff;
    logic                 light_jump;
    logic                 gyro_hit;
    logic [SW:0]          gyro_diff [3];
    logic [SW:0]          gyro_mag [3];
    logic [SW-1:0]        accel_mag [3];

    assign sample.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && sample.valid)
        begin
            light_reg    <= sample.light_level;
            light_ok_reg <= sample.light_valid;
            gyro_reg[0]  <= sample.gyro_x;
            gyro_reg[1]  <= sample.gyro_y;
            gyro_reg[2]  <= sample.gyro_z;
            accel_reg[0] <= sample.accel_x;
            accel_reg[1] <= sample.accel_y;
            accel_reg[2] <= sample.accel_z;
        end
    end

    always_comb
    begin
        light_eff  = light_ok_reg ? light_reg : last_light_reg;
        light_diff = (light_eff >= last_light_reg) ? light_eff - last_light_reg
                                                   : last_light_reg - light_eff;
        light_jump = LCW'(light_diff) > LCW'(cfg.light_thr);
        gyro_hit   = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            gyro_diff[i] = {gyro_reg[i][SW-1], gyro_reg[i]}
                         - {last_gyro_reg[i][SW-1], last_gyro_reg[i]};
            gyro_mag[i]  = gyro_diff[i][SW] ? -gyro_diff[i] : gyro_diff[i];
            if (GW'(gyro_mag[i]) > GW'(cfg.gyro_thr))
            begin
                gyro_hit = 1'b1;
            end
            // most negative value wraps onto itself, which reads right as unsigned
            accel_mag[i] = accel_reg[i][SW-1] ? -accel_reg[i] : accel_reg[i];
        end
    end

    // previous readings and the priming flag move with each tick leaving stage one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg     <= 1'b0;
            last_light_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                last_gyro_reg[i] <= '0;
            end
            flags_reg      <= '0;
        end
        else if (en)
        begin
            flags_reg.valid       <= s1_valid_reg;
            flags_reg.live        <= primed_reg;
            flags_reg.gyro_motion <= primed_reg && gyro_hit;
            flags_reg.light_jump  <= primed_reg && light_jump;
            if (s1_valid_reg)
            begin
                primed_reg     <= 1'b1;
                last_light_reg <= light_eff;
                for (int i = 0; i < 3; i++)
                begin
                    last_gyro_reg[i] <= gyro_reg[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && s1_valid_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= accel_mag[i] * accel_mag[i];
            end
        end
    end

    assign flags = flags_reg;
    assign accel_sq = sq_reg;

endmodule

@@ rtl/mlas_fsm.sv @@
// magnitude compare, alarm phase machine with tick timer, result register
module mlas_fsm
    import mlas_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cfg_t                      cfg,
    input  det_flags_t                flags,
    input  logic [2*SAMPLE_WIDTH-1:0] accel_sq [3],
    output logic                      en,
    mlas_result_if.source             result
);

    localparam int SQW = 2 * SAMPLE_WIDTH;
    localparam int MW  = (SQW > MOTION_SQ_W) ? SQW : MOTION_SQ_W;

    logic [1:0]        phase_reg, phase_next;
    logic              running_reg, running_next;
    logic              first_buzz_reg, first_buzz_next;
    logic [TICK_W-1:0] tick_reg, tick_next;

    logic              res_valid_reg;
    logic [1:0]        mode_reg;
    logic              buzzer_reg;
    logic              motion_reg;
    logic              jump_reg;

    logic [SQW-1:0]    mag_sum;
    logic              motion;
    logic              jump;
    logic [TICK_W-1:0] limit;
    logic              step;

    assign en = !res_valid_reg || result.ready;
    // three squares of values at most half range always fit the square width
    assign mag_sum = accel_sq[0] + accel_sq[1] + accel_sq[2];
    assign motion  = flags.gyro_motion
                   || (flags.live && (MW'(mag_sum) > MW'(cfg.motion_sq)));
    assign jump    = flags.light_jump;
    assign step    = en && flags.valid && flags.live;

    always_comb
    begin
        phase_next      = phase_reg;
        running_next    = running_reg;
        first_buzz_next = first_buzz_reg;
        tick_next       = tick_reg;
        limit           = (phase_reg == PH_BUZZ) ? cfg.buzz_ticks : cfg.wait_ticks;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (motion)
                begin
                    phase_next = PH_INTERIM;
                end
            end
            PH_INTERIM:
            begin
                if (jump)
                begin
                    phase_next      = PH_BUZZ;
                    first_buzz_next = 1'b1;
                end
            end
            PH_BUZZ, PH_WAIT:
            begin
                running_next = 1'b1;
                if (!running_reg)
                begin
                    tick_next = '0;
                end
                else if (tick_reg != TICK_MAX)
                begin
                    tick_next = tick_reg + 1'b1;
                end
                priority if (!first_buzz_reg && jump)
                begin
                    running_next = 1'b0;
                    phase_next   = PH_IDLE;
                end
                else if (tick_next >= limit)
                begin
                    running_next = 1'b0;
                    if (phase_reg == PH_BUZZ)
                    begin
                        phase_next = PH_WAIT;
                    end
                    else
                    begin
                        first_buzz_next = 1'b0;
                        phase_next      = PH_BUZZ;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            running_reg    <= 1'b0;
            first_buzz_reg <= 1'b1;
            tick_reg       <= '0;
            res_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            res_valid_reg <= flags.valid;
            if (step)
            begin
                phase_reg      <= phase_next;
                running_reg    <= running_next;
                first_buzz_reg <= first_buzz_next;
                tick_reg       <= tick_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && flags.valid)
        begin
            if (flags.live)
            begin
                mode_reg   <= phase_next;
                buzzer_reg <= (phase_next == PH_BUZZ) && running_next;
            end
            else
            begin
                mode_reg   <= phase_reg;
                buzzer_reg <= (phase_reg == PH_BUZZ) && running_reg;
            end
            motion_reg <= motion;
            jump_reg   <= jump;
        end
    end

    assign result.valid           = res_valid_reg;
    assign result.alarm_mode      = mode_reg;
    assign result.buzzer_on       = buzzer_reg;
    assign result.motion_seen     = motion_reg;
    assign result.light_jump_seen = jump_reg;

endmodule

@@ rtl/motion_light_alarm_sequencer.sv @@
// top level of the motion light alarm sequencer
// Takes one sensor sample per clock cycle and returns one result per sample, in
// order, after passing through an input register, a stage holding the
// change flags and accelerometer squares, and the result register that also
// carries the alarm phase. All three stages advance together whenever the result
// register is empty or being taken, so a stalled result holds the whole pipeline.
// The first sample after reset only loads the previous-reading store. Thresholds
// and phase tick counts are set through the apb port and should be written while
// no samples are in flight.
module motion_light_alarm_sequencer
    import mlas_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int LIGHT_WIDTH  = LIGHT_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    mlas_sample_if.sink           sample,
    mlas_result_if.source         result
);

    cfg_t                      cfg;
    det_flags_t                flags;
    logic [2*SAMPLE_WIDTH-1:0] accel_sq [3];
    logic                      en;

    mlas_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mlas_detect #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .LIGHT_WIDTH  (LIGHT_WIDTH)
    ) u_detect (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .cfg      (cfg),
        .sample   (sample),
        .flags    (flags),
        .accel_sq (accel_sq)
    );

    mlas_fsm #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_fsm (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .flags    (flags),
        .accel_sq (accel_sq),
        .en       (en),
        .result   (result)
    );

endmodule
